[src/sbph_pkg.sv]
// Package for the spectrum bar peak hold meter: field widths, register codes,
// reset values and the per-column state record. No dependencies.
package sbph_pkg;

  localparam int COL_W      = 6;
  localparam int LEVEL_W    = 17;
  localparam int BAR_W      = 4;
  localparam int PROW_W     = 3;
  localparam int HUE_W      = 8;
  localparam int HOLD_W     = 8;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_W     = 16;

  localparam int NUM_COLUMNS_DEF = 60;
  localparam int NUM_ROWS_DEF    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_MAX     = 2'd2;

  localparam logic [HOLD_W-1:0] HOLD_FRAMES_RST = 8'd20;
  localparam logic [STEP_W-1:0] FALL_STEP_RST   = 16'd2621;
  localparam logic [HUE_W-1:0]  HUE_MAX_RST     = 8'd192;

  typedef struct packed {
    logic [LEVEL_W-1:0] band;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } col_state_t;

endpackage

[src/sbph_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sbph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/sbph_store.sv]
// Per-column state store: RAM, per-column valid bits that read as zero state
// after reset, and forwarding of a write to a read of the same column.
// Depends on sbph_pkg and sbph_ram.
module sbph_store
  import sbph_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [$clog2(NUM_COLUMNS)-1:0] rd_addr,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_COLUMNS)-1:0] wr_addr,
  input  col_state_t                     wr_data,
  output col_state_t                     rd_state
);

  logic [NUM_COLUMNS-1:0] vld_r;
  logic                   rd_vld_r;
  logic                   byp_r;
  col_state_t             byp_data_r;
  logic [$bits(col_state_t)-1:0] ram_q;

  sbph_ram #(
    .WIDTH ($bits(col_state_t)),
    .DEPTH (NUM_COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
        byp_r    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr_data;
    end
  end

  always_comb begin
    if (byp_r) begin
      rd_state = byp_data_r;
    end else if (rd_vld_r) begin
      rd_state = col_state_t'(ram_q);
    end else begin
      rd_state = '0;
    end
  end

endmodule

[src/sbph_calc.sv]
// Peak hold and decay update for one column, and scaling of level and peak
// to bar rows and the peak dot row. Depends on sbph_pkg.
module sbph_calc
  import sbph_pkg::*;
#(
  parameter int NUM_ROWS = NUM_ROWS_DEF
) (
  input  col_state_t          cur,
  input  logic [LEVEL_W-1:0]  level,
  input  logic                fresh,
  input  logic [HOLD_W-1:0]   hold_frames,
  input  logic [STEP_W-1:0]   fall_step,
  output col_state_t          nxt,
  output logic [BAR_W-1:0]    bar_rows,
  output logic [PROW_W-1:0]   peak_row
);

  localparam int RMW  = $clog2(NUM_ROWS + 1);
  localparam int PW   = LEVEL_W + RMW;
  localparam int RIW  = PW - FRAC_W;
  localparam logic [RIW-1:0] BAR_CAP  = RIW'(NUM_ROWS);
  localparam logic [RIW-1:0] PEAK_CAP = RIW'(NUM_ROWS - 1);

  logic [PW-1:0]  bar_prod;
  logic [PW-1:0]  peak_prod;
  logic [RIW-1:0] bar_int;
  logic [RIW-1:0] peak_int;
  logic [RIW-1:0] bar_sat;
  logic [RIW-1:0] peak_sat;
  logic [RIW-1:0] prow_full;

  always_comb begin
    nxt = cur;
    if (fresh) begin
      nxt.band = level;
      if (level >= cur.peak) begin
        nxt.peak = level;
        nxt.hold = hold_frames;
      end else if (cur.hold != '0) begin
        nxt.hold = cur.hold - 1'b1;
      end else if (cur.peak > LEVEL_W'(fall_step)) begin
        nxt.peak = cur.peak - LEVEL_W'(fall_step);
      end else begin
        nxt.peak = '0;
      end
    end
  end

  always_comb begin
    bar_prod  = PW'(nxt.band) * PW'(NUM_ROWS);
    peak_prod = PW'(nxt.peak) * PW'(NUM_ROWS - 1);
    bar_int   = bar_prod[PW-1:FRAC_W];
    peak_int  = peak_prod[PW-1:FRAC_W];
    bar_sat   = (bar_int > BAR_CAP) ? BAR_CAP : bar_int;
    peak_sat  = (peak_int > PEAK_CAP) ? PEAK_CAP : peak_int;
    prow_full = PEAK_CAP - peak_sat;
  end

  assign bar_rows = BAR_W'(bar_sat);
  assign peak_row = PROW_W'(prow_full);

endmodule

[src/spectrum_bar_peak_hold_meter.sv]
// Top level of the spectrum bar peak hold meter: configuration registers,
// input stage, column store, update logic and result register.
// Depends on sbph_pkg, sbph_store and sbph_calc.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    in_column, in_level, in_fresh
//   out       out_valid / out_ready  out_column, out_bar_rows, out_peak_row,
//                                    out_column_hue
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle is accepted while the output is not stalled; its result
// passes through the input stage register and the result register. The
// column RAM read is registered on the edge that loads the input stage. The
// column store reads as zero after reset through per-column valid bits, so no
// clearing pass is needed. A stalled output holds the middle stage, and the
// input is refused only while both stages are full.
module spectrum_bar_peak_hold_meter
  import sbph_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = NUM_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COL_W-1:0]      in_column,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic                  in_fresh,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COL_W-1:0]      out_column,
  output logic [BAR_W-1:0]      out_bar_rows,
  output logic [PROW_W-1:0]     out_peak_row,
  output logic [HUE_W-1:0]      out_column_hue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(NUM_COLUMNS);
  localparam int HUE_D  = NUM_COLUMNS - 1;
  localparam int HUE_S  = COL_W + HUE_W + $clog2(HUE_D);
  localparam int HUE_M  = ((1 << HUE_S) + HUE_D - 1) / HUE_D;
  localparam int MW     = COL_W + HUE_W + 2;
  localparam int KW     = HUE_W + MW;
  localparam int HPW    = COL_W + KW;
  localparam logic [8:0]    NCOL_V    = 9'(NUM_COLUMNS);
  localparam logic [KW-1:0] HUE_K_RST = KW'(HUE_MAX_RST) * KW'(HUE_M);

  logic [HOLD_W-1:0]  hold_frames_r;
  logic [STEP_W-1:0]  fall_step_r;
  logic [HUE_W-1:0]   hue_max_r;
  logic [KW-1:0]      hue_k_r;

  logic               s1_valid_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [LEVEL_W-1:0] s1_level_r;
  logic               s1_fresh_r;
  logic               s1_inr_r;

  logic               out_valid_r;
  logic [COL_W-1:0]   out_column_r;
  logic [BAR_W-1:0]   out_bar_r;
  logic [PROW_W-1:0]  out_prow_r;
  logic [HUE_W-1:0]   out_hue_r;

  logic               accept;
  logic               s1_adv;
  logic               in_inr;
  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      s1_addr;
  logic               wr_en;
  col_state_t         cur_state;
  col_state_t         nxt_state;
  logic [BAR_W-1:0]   calc_bar;
  logic [PROW_W-1:0]  calc_prow;
  logic [HPW-1:0]     hue_prod;
  logic [HUE_W-1:0]   hue_nxt;
  logic [BAR_W-1:0]   bar_nxt;
  logic [PROW_W-1:0]  prow_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_frames_r <= HOLD_FRAMES_RST;
      fall_step_r   <= FALL_STEP_RST;
      hue_max_r     <= HUE_MAX_RST;
      hue_k_r       <= HUE_K_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOLD_FRAMES: hold_frames_r <= cfg_data[HOLD_W-1:0];
        REG_FALL_STEP:   fall_step_r   <= cfg_data[STEP_W-1:0];
        REG_HUE_MAX: begin
          hue_max_r <= cfg_data[HUE_W-1:0];
          hue_k_r   <= KW'(cfg_data[HUE_W-1:0]) * KW'(HUE_M);
        end
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign in_inr   = 9'(in_column) < NCOL_V;
  assign in_addr  = AW'(in_column);
  assign s1_addr  = AW'(s1_col_r);
  assign wr_en    = s1_adv && s1_inr_r && s1_fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= in_column;
      s1_level_r <= in_level;
      s1_fresh_r <= in_fresh;
      s1_inr_r   <= in_inr;
    end
  end

  sbph_store #(
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept && in_inr),
    .rd_addr  (in_addr),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_data  (nxt_state),
    .rd_state (cur_state)
  );

  sbph_calc #(
    .NUM_ROWS (NUM_ROWS)
  ) u_calc (
    .cur         (cur_state),
    .level       (s1_level_r),
    .fresh       (s1_fresh_r),
    .hold_frames (hold_frames_r),
    .fall_step   (fall_step_r),
    .nxt         (nxt_state),
    .bar_rows    (calc_bar),
    .peak_row    (calc_prow)
  );

  always_comb begin
    hue_prod = HPW'(s1_col_r) * HPW'(hue_k_r);
    if (s1_inr_r) begin
      hue_nxt  = hue_prod[HUE_S +: HUE_W];
      bar_nxt  = calc_bar;
      prow_nxt = calc_prow;
    end else begin
      hue_nxt  = hue_max_r;
      bar_nxt  = '0;
      prow_nxt = PROW_W'(NUM_ROWS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_column_r <= s1_col_r;
      out_bar_r    <= bar_nxt;
      out_prow_r   <= prow_nxt;
      out_hue_r    <= hue_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_column     = out_column_r;
  assign out_bar_rows   = out_bar_r;
  assign out_peak_row   = out_prow_r;
  assign out_column_hue = out_hue_r;

endmodule
